@@ src/tia_pkg.sv @@
// Shared types, op codes and helpers of the typed integer ALU.
// No dependencies.
package tia_pkg;

    localparam int unsigned DIV_STAGES = 64;
    localparam logic [63:0] S32_MAX = 64'h0000_0000_7FFF_FFFF;
    localparam logic [63:0] INT64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] UINT32_MAX = 64'h0000_0000_FFFF_FFFF;
    localparam logic [63:0] UINT64_MAX = 64'hFFFF_FFFF_FFFF_FFFF;

    localparam logic [4:0] OP_NOT   = 5'd0;
    localparam logic [4:0] OP_COMPL = 5'd1;
    localparam logic [4:0] OP_NEG   = 5'd2;
    localparam logic [4:0] OP_ADD   = 5'd3;
    localparam logic [4:0] OP_SUB   = 5'd4;
    localparam logic [4:0] OP_MUL   = 5'd5;
    localparam logic [4:0] OP_DIV   = 5'd6;
    localparam logic [4:0] OP_REM   = 5'd7;
    localparam logic [4:0] OP_AND   = 5'd8;
    localparam logic [4:0] OP_OR    = 5'd9;
    localparam logic [4:0] OP_XOR   = 5'd10;
    localparam logic [4:0] OP_SHL   = 5'd11;
    localparam logic [4:0] OP_SHR   = 5'd12;
    localparam logic [4:0] OP_EQ    = 5'd13;
    localparam logic [4:0] OP_NE    = 5'd14;
    localparam logic [4:0] OP_LT    = 5'd15;
    localparam logic [4:0] OP_LE    = 5'd16;
    localparam logic [4:0] OP_GT    = 5'd17;
    localparam logic [4:0] OP_GE    = 5'd18;
    localparam logic [4:0] OP_SEXT  = 5'd19;
    localparam logic [4:0] OP_ZEXT  = 5'd20;
    localparam logic [4:0] OP_TRUNC = 5'd21;

    localparam logic [1:0] TY_INT32  = 2'd0;
    localparam logic [1:0] TY_INT64  = 2'd1;
    localparam logic [1:0] TY_UINT32 = 2'd2;
    localparam logic [1:0] TY_UINT64 = 2'd3;

    typedef struct packed {
        logic        vld;
        logic [4:0]  op;
        logic [1:0]  st;
        logic [1:0]  dt;
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] sa;
        logic [63:0] sb;
        logic [63:0] am;
        logic [63:0] bm;
        logic        an;
        logic        bn;
        logic        bzero;
        logic        azero;
        logic [5:0]  sh;
    } t_prep;

    typedef struct packed {
        logic        vld;
        logic [4:0]  op;
        logic [1:0]  st;
        logic [1:0]  dt;
        logic        an;
        logic        bn;
        logic        bzero;
        logic        azero;
        logic        bad;
        logic [63:0] value;
        logic [63:0] pp_ll;
        logic [31:0] pp_lh;
        logic [31:0] pp_hl;
    } t_side;

    function automatic logic [63:0] type_mask(input logic [1:0] t);
        return t[0] ? UINT64_MAX : UINT32_MAX;
    endfunction

    function automatic logic [63:0] type_max(input logic [1:0] t);
        logic [63:0] m;
        case (t)
            TY_INT32:  m = S32_MAX;
            TY_INT64:  m = INT64_MAX;
            TY_UINT32: m = UINT32_MAX;
            default:   m = UINT64_MAX;
        endcase
        return m;
    endfunction

endpackage

@@ src/tia_prep.sv @@
// Input stage: masks operands, sign-extends them and forms divider magnitudes.
// Depends on tia_pkg.
module tia_prep import tia_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_vld,
    input  logic [4:0]  i_op,
    input  logic [1:0]  i_src_type,
    input  logic [1:0]  i_dst_type,
    input  logic [63:0] i_opnd_a,
    input  logic [63:0] i_opnd_b,
    output t_prep       o_prep
);

    t_prep r_prep;
    t_prep n_prep;
    logic [63:0] mask;
    logic        sgn;

    always_comb begin
        mask = type_mask(i_src_type);
        sgn  = !i_src_type[1];
        n_prep.vld   = i_vld;
        n_prep.op    = i_op;
        n_prep.st    = i_src_type;
        n_prep.dt    = i_dst_type;
        n_prep.a     = i_opnd_a & mask;
        n_prep.b     = i_opnd_b & mask;
        if (i_src_type[0] || !sgn) begin
            n_prep.sa = n_prep.a;
            n_prep.sb = n_prep.b;
        end else begin
            n_prep.sa = {{32{i_opnd_a[31]}}, i_opnd_a[31:0]};
            n_prep.sb = {{32{i_opnd_b[31]}}, i_opnd_b[31:0]};
        end
        n_prep.an    = sgn && n_prep.sa[63];
        n_prep.bn    = sgn && n_prep.sb[63];
        n_prep.am    = n_prep.an ? (~n_prep.sa + 64'd1) : n_prep.sa;
        n_prep.bm    = n_prep.bn ? (~n_prep.sb + 64'd1) : n_prep.sb;
        n_prep.bzero = (n_prep.b == 64'd0);
        n_prep.azero = (n_prep.a == 64'd0);
        n_prep.sh    = i_opnd_b[5:0] & (i_src_type[0] ? 6'd63 : 6'd31);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prep.vld <= 1'b0;
        end else if (i_en) begin
            r_prep.vld <= n_prep.vld;
        end
        if (i_en) begin
            r_prep.op    <= n_prep.op;
            r_prep.st    <= n_prep.st;
            r_prep.dt    <= n_prep.dt;
            r_prep.a     <= n_prep.a;
            r_prep.b     <= n_prep.b;
            r_prep.sa    <= n_prep.sa;
            r_prep.sb    <= n_prep.sb;
            r_prep.am    <= n_prep.am;
            r_prep.bm    <= n_prep.bm;
            r_prep.an    <= n_prep.an;
            r_prep.bn    <= n_prep.bn;
            r_prep.bzero <= n_prep.bzero;
            r_prep.azero <= n_prep.azero;
            r_prep.sh    <= n_prep.sh;
        end
    end

    assign o_prep = r_prep;

endmodule

@@ src/tia_alu.sv @@
// Combinational operations and multiplier partial products.
// Depends on tia_pkg.
module tia_alu import tia_pkg::*; (
    input  t_prep i_prep,
    output t_side o_side
);

    logic lt_ab;
    logic lt_ba;

    always_comb begin
        if (!i_prep.st[1]) begin
            lt_ab = $signed(i_prep.sa) < $signed(i_prep.sb);
            lt_ba = $signed(i_prep.sb) < $signed(i_prep.sa);
        end else begin
            lt_ab = i_prep.a < i_prep.b;
            lt_ba = i_prep.b < i_prep.a;
        end
        o_side.vld   = i_prep.vld;
        o_side.op    = i_prep.op;
        o_side.st    = i_prep.st;
        o_side.dt    = i_prep.dt;
        o_side.an    = i_prep.an;
        o_side.bn    = i_prep.bn;
        o_side.bzero = i_prep.bzero;
        o_side.azero = i_prep.azero;
        o_side.pp_ll = i_prep.a[31:0] * i_prep.b[31:0];
        o_side.pp_lh = 32'(i_prep.a[31:0] * i_prep.b[63:32]);
        o_side.pp_hl = 32'(i_prep.a[63:32] * i_prep.b[31:0]);
        o_side.bad   = 1'b0;
        o_side.value = 64'd0;
        case (i_prep.op)
            OP_NOT:   o_side.value = {63'd0, i_prep.azero};
            OP_COMPL: o_side.value = ~i_prep.a;
            OP_NEG:   o_side.value = ~i_prep.a + 64'd1;
            OP_ADD:   o_side.value = i_prep.a + i_prep.b;
            OP_SUB:   o_side.value = i_prep.a - i_prep.b;
            OP_MUL, OP_DIV, OP_REM: o_side.value = 64'd0;
            OP_AND:   o_side.value = i_prep.a & i_prep.b;
            OP_OR:    o_side.value = i_prep.a | i_prep.b;
            OP_XOR:   o_side.value = i_prep.a ^ i_prep.b;
            OP_SHL:   o_side.value = i_prep.a << i_prep.sh;
            OP_SHR: begin
                if (!i_prep.st[1]) begin
                    o_side.value = 64'($signed(i_prep.sa) >>> i_prep.sh);
                end else begin
                    o_side.value = i_prep.a >> i_prep.sh;
                end
            end
            OP_EQ:    o_side.value = {63'd0, i_prep.a == i_prep.b};
            OP_NE:    o_side.value = {63'd0, i_prep.a != i_prep.b};
            OP_LT:    o_side.value = {63'd0, lt_ab};
            OP_LE:    o_side.value = {63'd0, !lt_ba};
            OP_GT:    o_side.value = {63'd0, lt_ba};
            OP_GE:    o_side.value = {63'd0, !lt_ab};
            OP_SEXT: begin
                if (i_prep.st == TY_INT32 && i_prep.dt[0]) o_side.value = i_prep.sa;
                else o_side.bad = 1'b1;
            end
            OP_ZEXT: begin
                if (i_prep.st == TY_UINT32 && i_prep.dt[0]) o_side.value = i_prep.a;
                else o_side.bad = 1'b1;
            end
            OP_TRUNC: begin
                if (i_prep.st[0] && !i_prep.dt[0]) o_side.value = i_prep.a;
                else o_side.bad = 1'b1;
            end
            default:  o_side.bad = 1'b1;
        endcase
    end

endmodule

@@ src/tia_div.sv @@
// Restoring divider pipeline, one quotient bit per stage, on magnitudes.
// Depends on tia_pkg.
module tia_div import tia_pkg::*; (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [63:0] i_dividend,
    input  logic [63:0] i_divisor,
    output logic [63:0] o_quo,
    output logic [63:0] o_rem
);

    logic [63:0] r_rem [DIV_STAGES];
    logic [63:0] r_dvd [DIV_STAGES];
    logic [63:0] r_dvs [DIV_STAGES];
    logic [63:0] n_rem [DIV_STAGES];
    logic [63:0] n_dvd [DIV_STAGES];
    logic [63:0] n_dvs [DIV_STAGES];

    always_comb begin
        for (int k = 0; k < DIV_STAGES; k++) begin
            logic [63:0] rem_in;
            logic [63:0] dvd_in;
            logic [63:0] dvs_in;
            logic [64:0] trial;
            logic        ge;
            if (k == 0) begin
                rem_in = 64'd0;
                dvd_in = i_dividend;
                dvs_in = i_divisor;
            end else begin
                rem_in = r_rem[k-1];
                dvd_in = r_dvd[k-1];
                dvs_in = r_dvs[k-1];
            end
            trial    = {rem_in, dvd_in[63]};
            ge       = trial >= {1'b0, dvs_in};
            n_rem[k] = ge ? 64'(trial - {1'b0, dvs_in}) : trial[63:0];
            n_dvd[k] = {dvd_in[62:0], ge};
            n_dvs[k] = dvs_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < DIV_STAGES; k++) begin
                r_rem[k] <= n_rem[k];
                r_dvd[k] <= n_dvd[k];
                r_dvs[k] <= n_dvs[k];
            end
        end
    end

    assign o_quo = r_dvd[DIV_STAGES-1];
    assign o_rem = r_rem[DIV_STAGES-1];

endmodule

@@ src/typed_integer_alu.sv @@
// Top level of the typed integer ALU: input stage, combinational ALU, divider
// pipeline, side delay line and output stage. Depends on tia_pkg and submodules.
//
// Usage:
//   Input channel: i_valid / o_stall with i_op, i_src_type, i_dst_type,
//   i_opnd_a, i_opnd_b. A transfer happens at a clock edge where i_valid is
//   high and o_stall is low.
//   Output channel: o_valid / i_stall with o_value_out, o_a_is_zero,
//   o_bad_combo. A transfer happens where o_valid is high and i_stall low.
// Path: an accepted input passes one input stage, 64 divider stages and one
//   output stage in that order, each advancing only while the pipeline is not
//   stalled. Every op takes the same path length, so results leave in order.
// Throughput: one operation per cycle unless i_stall holds the pipeline;
//   the divider retires one quotient bit per stage and the 64x64 multiply is
//   split into 32x32 partial products summed one stage later.
// Reset: i_rst_n low (synchronous) clears all valid bits; payload registers
//   keep whatever they hold.
// Stall: when a result is waiting and i_stall is high, the whole pipeline,
//   bubbles included, holds; it advances while the output register is empty or taken.
module typed_integer_alu import tia_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [4:0]  i_op,
    input  logic [1:0]  i_src_type,
    input  logic [1:0]  i_dst_type,
    input  logic [63:0] i_opnd_a,
    input  logic [63:0] i_opnd_b,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [63:0] o_value_out,
    output logic        o_a_is_zero,
    output logic        o_bad_combo
);

    logic        en;
    t_prep       prep;
    t_side       alu_side;
    t_side       r_side [DIV_STAGES];
    t_side       n_side [DIV_STAGES];
    logic [63:0] div_quo;
    logic [63:0] div_rem;
    logic        r_out_vld;
    logic [63:0] r_out_value;
    logic        r_out_azero;
    logic        r_out_bad;
    logic [63:0] n_out_value;

    // Advance whenever the output register is empty or being taken.
    assign en      = !r_out_vld || !i_stall;
    assign o_stall = !en;

    tia_prep u_prep (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_vld      (i_valid),
        .i_op       (i_op),
        .i_src_type (i_src_type),
        .i_dst_type (i_dst_type),
        .i_opnd_a   (i_opnd_a),
        .i_opnd_b   (i_opnd_b),
        .o_prep     (prep)
    );

    tia_alu u_alu (
        .i_prep (prep),
        .o_side (alu_side)
    );

    tia_div u_div (
        .i_clk      (i_clk),
        .i_en       (en),
        .i_dividend (prep.am),
        .i_divisor  (prep.bm),
        .o_quo      (div_quo),
        .o_rem      (div_rem)
    );

    // Side line runs beside the divider; stage one folds the multiply sum.
    always_comb begin
        for (int k = 0; k < DIV_STAGES; k++) begin
            if (k == 0) begin
                n_side[k] = alu_side;
            end else begin
                n_side[k] = r_side[k-1];
            end
            if (k == 1 && r_side[0].op == OP_MUL) begin
                n_side[k].value = r_side[0].pp_ll
                                + {r_side[0].pp_lh + r_side[0].pp_hl, 32'd0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DIV_STAGES; k++) r_side[k].vld <= 1'b0;
        end else if (en) begin
            for (int k = 0; k < DIV_STAGES; k++) r_side[k].vld <= n_side[k].vld;
        end
        if (en) begin
            for (int k = 0; k < DIV_STAGES; k++) begin
                r_side[k].op    <= n_side[k].op;
                r_side[k].st    <= n_side[k].st;
                r_side[k].dt    <= n_side[k].dt;
                r_side[k].an    <= n_side[k].an;
                r_side[k].bn    <= n_side[k].bn;
                r_side[k].bzero <= n_side[k].bzero;
                r_side[k].azero <= n_side[k].azero;
                r_side[k].bad   <= n_side[k].bad;
                r_side[k].value <= n_side[k].value;
                r_side[k].pp_ll <= n_side[k].pp_ll;
                r_side[k].pp_lh <= n_side[k].pp_lh;
                r_side[k].pp_hl <= n_side[k].pp_hl;
            end
        end
    end

    // Output stage: apply division signs and the divide-by-zero rule, zero bad combinations, mask.
    always_comb begin
        t_side last;
        logic [63:0] v;
        last = r_side[DIV_STAGES-1];
        v    = last.value;
        if (last.op == OP_DIV) begin
            if (last.bzero) v = type_max(last.st);
            else if (last.an != last.bn) v = ~div_quo + 64'd1;
            else v = div_quo;
        end else if (last.op == OP_REM) begin
            if (last.bzero) v = 64'd0;
            else if (last.an) v = ~div_rem + 64'd1;
            else v = div_rem;
        end
        if (last.bad) begin
            n_out_value = 64'd0;
        end else if (last.op inside {OP_SEXT, OP_ZEXT, OP_TRUNC}) begin
            n_out_value = v & type_mask(last.dt);
        end else begin
            n_out_value = v & type_mask(last.st);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= r_side[DIV_STAGES-1].vld;
        end
        if (en) begin
            r_out_value <= n_out_value;
            r_out_azero <= r_side[DIV_STAGES-1].azero;
            r_out_bad   <= r_side[DIV_STAGES-1].bad;
        end
    end

    assign o_valid     = r_out_vld;
    assign o_value_out = r_out_value;
    assign o_a_is_zero = r_out_azero;
    assign o_bad_combo = r_out_bad;

    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_bad_combo |-> o_value_out == 64'd0)
        else $error("bad combination with nonzero value");

    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> prep.vld)
        else $error("accepted input lost at input stage");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("valid after reset");

endmodule

@@ dv/testbench.sv @@
// Self-checking testbench of typed_integer_alu: directed and random operations,
// predicted in the testbench and compared in order. Depends on tia_pkg and the RTL.
module testbench import tia_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY = 66;

    typedef struct {
        logic [63:0] value;
        logic        zero;
        logic        bad;
    } t_alu_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [4:0]  i_op = '0;
    logic [1:0]  i_src_type = '0;
    logic [1:0]  i_dst_type = '0;
    logic [63:0] i_opnd_a = '0;
    logic [63:0] i_opnd_b = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [63:0] o_value_out;
    logic        o_a_is_zero;
    logic        o_bad_combo;

    t_alu_result pending_results[$];
    int          error_count = 0;
    bit          idle_on = 1'b1;   // random gaps on both sides
    bit          hold_output = 1'b0;

    typed_integer_alu u_top (.*);

    always #5 i_clk = ~i_clk;

    // Widen a value of type t to 64 bits, signed types by sign.
    function automatic logic [63:0] widen(input logic [63:0] v, input logic [1:0] t);
        if (t[0]) return v;
        if (!t[1] && v[31]) return {32'hFFFF_FFFF, v[31:0]};
        return {32'h0, v[31:0]};
    endfunction

    function automatic logic [63:0] quot_or_rem(input logic [63:0] a, input logic [63:0] b,
                                                input logic [1:0] t, input bit want_rem);
        logic [63:0] msk, sa, sb, am, bm, q, r;
        bit an, bn;
        msk = t[0] ? 64'hFFFF_FFFF_FFFF_FFFF : 64'hFFFF_FFFF;
        an = 0;
        bn = 0;
        if ((b & msk) == 0) begin
            if (want_rem) return 0;
            case (t)
                TY_INT32: return 64'h7FFF_FFFF;
                TY_INT64: return 64'h7FFF_FFFF_FFFF_FFFF;
                TY_UINT32: return 64'hFFFF_FFFF;
                default: return 64'hFFFF_FFFF_FFFF_FFFF;
            endcase
        end
        if (!t[1]) begin
            sa = widen(a, t);
            sb = widen(b, t);
            an = sa[63];
            bn = sb[63];
            am = an ? -sa : sa;
            bm = bn ? -sb : sb;
        end else begin
            am = a & msk;
            bm = b & msk;
        end
        q = am / bm;
        r = am % bm;
        if (an != bn) q = -q;
        if (an) r = -r;
        return (want_rem ? r : q) & msk;
    endfunction

    function automatic t_alu_result evaluate(input logic [4:0] op, input logic [1:0] st,
                                             input logic [1:0] dt, input logic [63:0] ia,
                                             input logic [63:0] ib);
        t_alu_result res;
        logic [63:0] msk, a, b, sa, sb, v;
        int sh;
        bit sgn, bad;
        msk = st[0] ? 64'hFFFF_FFFF_FFFF_FFFF : 64'hFFFF_FFFF;
        a = ia & msk;
        b = ib & msk;
        sgn = !st[1];
        sh = st[0] ? int'(b[5:0]) : int'(b[4:0]);
        sa = widen(a, st);
        sb = widen(b, st);
        if (sgn) begin
            sa[63] = ~sa[63];
            sb[63] = ~sb[63];
        end
        v = 0;
        bad = 0;
        case (op)
            OP_NOT:   v = (a == 0);
            OP_COMPL: v = ~a;
            OP_NEG:   v = -a;
            OP_ADD:   v = a + b;
            OP_SUB:   v = a - b;
            OP_MUL:   v = a * b;
            OP_DIV:   v = quot_or_rem(a, b, st, 0);
            OP_REM:   v = quot_or_rem(a, b, st, 1);
            OP_AND:   v = a & b;
            OP_OR:    v = a | b;
            OP_XOR:   v = a ^ b;
            OP_SHL:   v = a << sh;
            OP_SHR: begin
                if (sgn) v = $signed(widen(a, st)) >>> sh;
                else v = a >> sh;
            end
            OP_EQ:    v = (a == b);
            OP_NE:    v = (a != b);
            OP_LT:    v = (sa < sb);
            OP_LE:    v = !(sb < sa);
            OP_GT:    v = (sb < sa);
            OP_GE:    v = !(sa < sb);
            OP_SEXT:  if (st == TY_INT32 && dt[0]) v = widen(a, st); else bad = 1;
            OP_ZEXT:  if (st == TY_UINT32 && dt[0]) v = a; else bad = 1;
            OP_TRUNC: if (st[0] && !dt[0]) v = a & 64'hFFFF_FFFF; else bad = 1;
            default:  bad = 1;
        endcase
        if (bad) v = 0;
        else if (op >= OP_SEXT) v &= dt[0] ? 64'hFFFF_FFFF_FFFF_FFFF : 64'hFFFF_FFFF;
        else v &= msk;
        res.value = v;
        res.zero = (a == 0);
        res.bad = bad;
        return res;
    endfunction

    // Offer one operation, hold it until the transfer, record its prediction.
    // Valid stays high after the transfer; idle gaps and the callers drop it.
    task automatic send_op(input logic [4:0] op, input logic [1:0] st, input logic [1:0] dt,
                           input logic [63:0] a, input logic [63:0] b);
        while (idle_on && $urandom_range(99) < 27) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_op <= op;
        i_src_type <= st;
        i_dst_type <= dt;
        i_opnd_a <= a;
        i_opnd_b <= b;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        pending_results.push_back(evaluate(op, st, dt, a, b));
    endtask

    // Output side: random stall, or a forced hold.
    always @(posedge i_clk) begin
        i_stall <= hold_output || (idle_on && $urandom_range(99) < 27);
    end

    // Compare every result transfer with the oldest prediction.
    always @(posedge i_clk) begin
        t_alu_result exp_r;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result value_out=%h", o_value_out);
                error_count++;
            end else begin
                exp_r = pending_results.pop_front();
                if (o_value_out !== exp_r.value) begin
                    $error("value_out expected %h actual %h", exp_r.value, o_value_out);
                    error_count++;
                end
                if (o_a_is_zero !== exp_r.zero) begin
                    $error("a_is_zero expected %b actual %b", exp_r.zero, o_a_is_zero);
                    error_count++;
                end
                if (o_bad_combo !== exp_r.bad) begin
                    $error("bad_combo expected %b actual %b", exp_r.bad, o_bad_combo);
                    error_count++;
                end
            end
        end
    end

    function automatic logic [63:0] edge_operand();
        case ($urandom_range(7))
            0: return 0;
            1: return 1;
            2: return 64'hFFFF_FFFF_FFFF_FFFF;
            3: return 64'h8000_0000;
            4: return 64'h8000_0000_0000_0000;
            5: return 64'h7FFF_FFFF;
            6: return {$urandom, $urandom} & 64'h3F;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic drain();
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_directed();
        send_op(OP_DIV, TY_INT32, TY_INT32, 64'h8000_0000, 64'hFFFF_FFFF);
        send_op(OP_REM, TY_INT32, TY_INT32, 64'h8000_0000, 64'hFFFF_FFFF);
        send_op(OP_DIV, TY_INT64, TY_INT32, 64'h8000_0000_0000_0000, '1);
        send_op(OP_REM, TY_INT64, TY_INT32, 64'h8000_0000_0000_0000, '1);
        for (int t = 0; t < 4; t++) begin
            send_op(OP_DIV, t[1:0], TY_INT32, 64'd7, 64'd0);
            send_op(OP_REM, t[1:0], TY_INT32, 64'd7, 64'd0);
        end
        send_op(OP_DIV, TY_INT32, TY_INT32, -64'd7, 64'd2);
        send_op(OP_REM, TY_INT32, TY_INT32, -64'd7, 64'd2);
        send_op(OP_SEXT, TY_INT32, TY_UINT64, 64'h8000_0000, 0);
        send_op(OP_SEXT, TY_UINT32, TY_INT64, 64'h8000_0000, 0);
        send_op(OP_ZEXT, TY_UINT32, TY_INT64, '1, 0);
        send_op(OP_ZEXT, TY_INT32, TY_INT32, '1, 0);
        send_op(OP_TRUNC, TY_UINT64, TY_UINT32, '1, 0);
        send_op(OP_TRUNC, TY_INT32, TY_UINT32, '1, 0);
        send_op(5'd31, TY_UINT64, TY_UINT64, 0, '1);
        send_op(5'd22, TY_INT64, TY_INT32, '1, '1);
        send_op(OP_SHR, TY_INT32, TY_INT32, 64'h8000_0000, 64'd63);
        send_op(OP_SHL, TY_UINT64, TY_INT32, '1, 64'd65);
        i_valid <= 1'b0;
        drain();
    endtask

    task automatic test_random(input int count);
        logic [4:0] op;
        for (int n = 0; n < count; n++) begin
            op = ($urandom_range(9) == 0) ? 5'($urandom_range(31)) : 5'($urandom_range(21));
            send_op(op, 2'($urandom), 2'($urandom),
                    $urandom_range(1) ? edge_operand() : {$urandom, $urandom},
                    $urandom_range(1) ? edge_operand() : {$urandom, $urandom});
        end
        i_valid <= 1'b0;
    endtask

    // Hold the output for a long stretch while the input keeps offering.
    task automatic test_backpressure();
        fork
            begin
                hold_output = 1'b1;
                repeat (200) @(posedge i_clk);
                hold_output = 1'b0;
            end
            test_random(150);
        join
        drain();
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(600);
        drain();
        idle_on = 1'b0;
        test_random(300);
        drain();
        idle_on = 1'b1;
        test_backpressure();
        test_random(350);
        drain();
        repeat (LATENCY + 10) @(posedge i_clk);
        if (error_count == 0 && pending_results.size() == 0)
            $display("typed_integer_alu regression: pass");
        else
            $display("typed_integer_alu regression: fail");
        $finish;
    end

    initial begin
        #2ms;
        $display("typed_integer_alu regression: fail");
        $finish;
    end
endmodule
